@@ rtl/sine_lut_interpolator_top_assert.svh @@
// Assertion macros for the sine lookup RTL; the pipeline control is their user.
// SLI_ASSERT checks only outside reset; SLI_ASSERT_ALWAYS checks during reset too.
`ifndef SINE_LUT_INTERPOLATOR_TOP_ASSERT_SVH
`define SINE_LUT_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SLI_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SLI_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SLI_ASSERT(name, prop, msg)
`define SLI_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ rtl/sli_pkg.sv @@
`timescale 1ns / 1ps

package sli_pkg;

    // Field and datapath widths
    localparam int C_ANGLE_W = 25;
    localparam int C_SINE_W  = 17;
    localparam int C_FRAC_W  = 8;
    localparam int C_DEG_W   = C_ANGLE_W - C_FRAC_W;
    localparam int C_IDX_W   = 7;
    localparam int C_VAL_W   = 16;
    localparam int C_DIFF_W  = 11;
    localparam int C_Q_W     = 8;
    localparam int C_REM_W   = 9;
    localparam int C_HALF_W  = 8;

    // Reciprocal of 360 scaled by 2^24; exact floor for degrees up to 65536
    localparam int                   C_RECIP_SHIFT = 24;
    localparam logic [15:0]          C_RECIP_360   = 16'd46604;
    localparam int                   C_RECIP_PROD_W = C_DEG_W + 16;

    localparam logic [C_REM_W-1:0]  C_FULL_TURN = 9'd360;
    localparam logic [C_REM_W-1:0]  C_HALF_TURN = 9'd180;
    localparam logic [C_HALF_W-1:0] C_QUARTER   = 8'd90;
    localparam logic [C_HALF_W-1:0] C_MIRROR_LO = 8'd179;
    localparam logic [C_HALF_W-1:0] C_MIRROR_HI = 8'd180;
    localparam logic [C_IDX_W-1:0]  C_LAST_IDX  = 7'd90;

    // sin(k deg) * 65535, k = 0..90
    localparam logic [C_VAL_W-1:0] C_QUARTER_TBL [0:90] = '{
        16'd0,     16'd1144,  16'd2287,  16'd3430,  16'd4571,  16'd5712,  16'd6850,
        16'd7987,  16'd9121,  16'd10252, 16'd11380, 16'd12505, 16'd13625, 16'd14742,
        16'd15854, 16'd16962, 16'd18064, 16'd19161, 16'd20251, 16'd21336, 16'd22414,
        16'd23486, 16'd24550, 16'd25607, 16'd26655, 16'd27696, 16'd28729, 16'd29752,
        16'd30767, 16'd31772, 16'd32768, 16'd33753, 16'd34728, 16'd35693, 16'd36647,
        16'd37589, 16'd38521, 16'd39440, 16'd40347, 16'd41243, 16'd42125, 16'd42995,
        16'd43851, 16'd44695, 16'd45524, 16'd46340, 16'd47142, 16'd47929, 16'd48702,
        16'd49460, 16'd50203, 16'd50930, 16'd51642, 16'd52339, 16'd53019, 16'd53683,
        16'd54331, 16'd54962, 16'd55577, 16'd56174, 16'd56755, 16'd57318, 16'd57864,
        16'd58392, 16'd58902, 16'd59395, 16'd59869, 16'd60325, 16'd60763, 16'd61182,
        16'd61583, 16'd61965, 16'd62327, 16'd62671, 16'd62996, 16'd63302, 16'd63588,
        16'd63855, 16'd64103, 16'd64331, 16'd64539, 16'd64728, 16'd64897, 16'd65047,
        16'd65176, 16'd65286, 16'd65375, 16'd65445, 16'd65495, 16'd65525, 16'd65535
    };

    // Load enables, one per pipeline register
    typedef struct packed {
        logic in_reg;
        logic stg_a;
        logic stg_b;
        logic stg_c;
        logic out_reg;
    } t_pipe_en;

    // Folded first-quarter position
    typedef struct packed {
        logic [C_IDX_W-1:0]  idx;
        logic [C_FRAC_W-1:0] frac;
        logic                interp;
        logic                neg;
    } t_fold;

    // Quarter-wave table read; entries past 90 read as zero
    function automatic logic [C_VAL_W-1:0] sli_quarter(input logic [C_IDX_W-1:0] idx);
        logic [C_VAL_W-1:0] val;
        val = '0;
        if (idx <= C_LAST_IDX) begin
            val = C_QUARTER_TBL[idx];
        end
        return val;
    endfunction

endpackage

@@ rtl/sine_lut_interpolator_top.sv @@
// A request passes five registers (input, magnitude/quotient, fold, table read,
// result) before o_valid rises.
// Throughput: one request per cycle unless back-pressure fills the pipe; each of the five registers advances on
// its own, so bubbles close up while a stalled result waits.
// Reset clears only the stage valid bits; datapath registers are not reset.
`timescale 1ns / 1ps

module sine_lut_interpolator_top import sli_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [C_ANGLE_W-1:0] i_angle,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [C_SINE_W-1:0]  o_sine
);

    t_pipe_en w_en;
    t_fold    w_fold;

    // Handshake and stage enables
    sli_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_en    (w_en)
    );

    // Range reduction to the first quarter
    sli_reduce u_reduce (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (i_angle),
        .o_fold  (w_fold)
    );

    // Table lookup and linear interpolation
    sli_interp u_interp (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_fold (w_fold),
        .o_sine (o_sine)
    );

endmodule

@@ rtl/sli_pipe_ctrl.sv @@
`timescale 1ns / 1ps
`include "sine_lut_interpolator_top_assert.svh"

module sli_pipe_ctrl import sli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_ready,
    output logic     o_ready,
    output logic     o_valid,
    output t_pipe_en o_en
);

    // r_vld[0] input register ... r_vld[4] result register
    logic [4:0] r_vld;
    logic [4:0] n_vld;
    logic [4:0] w_load;

    // A stage loads when empty or when its content moves on
    always_comb begin
        w_load[4] = !r_vld[4] || i_ready;
        w_load[3] = !r_vld[3] || w_load[4];
        w_load[2] = !r_vld[2] || w_load[3];
        w_load[1] = !r_vld[1] || w_load[2];
        w_load[0] = !r_vld[0] || w_load[1];
    end

    always_comb begin
        n_vld = r_vld;
        if (w_load[0]) n_vld[0] = i_valid;
        if (w_load[1]) n_vld[1] = r_vld[0];
        if (w_load[2]) n_vld[2] = r_vld[1];
        if (w_load[3]) n_vld[3] = r_vld[2];
        if (w_load[4]) n_vld[4] = r_vld[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_load[0];
    assign o_valid = r_vld[4];

    always_comb begin
        o_en.in_reg  = w_load[0];
        o_en.stg_a   = w_load[1];
        o_en.stg_b   = w_load[2];
        o_en.stg_c   = w_load[3];
        o_en.out_reg = w_load[4];
    end

    // A full pipe with a stalled output takes no new request
    `SLI_ASSERT(a_full_stall, (&r_vld && !i_ready) |-> !o_ready, "full pipe accepted a request")
    // An accepted request lands in the input register
    `SLI_ASSERT(a_accept_lands, (i_valid && o_ready) |=> r_vld[0], "accepted request was lost")
    // A taken result is refilled from the stage behind it
    `SLI_ASSERT(a_out_refill, (o_valid && i_ready) |=> (r_vld[4] == $past(r_vld[3])),
        "result register refill mismatch")

endmodule

@@ rtl/sli_reduce.sv @@
`timescale 1ns / 1ps

module sli_reduce import sli_pkg::*; (
    input  logic                        i_clk,
    input  t_pipe_en                    i_en,
    input  logic signed [C_ANGLE_W-1:0] i_angle,
    output t_fold                       o_fold
);

    // Input register
    logic [C_ANGLE_W-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (i_en.in_reg) begin
            r_angle <= i_angle;
        end
    end

    // Stage A: magnitude, whole degrees, quotient by 360
    logic [C_ANGLE_W-1:0]      w_mag;
    logic [C_RECIP_PROD_W-1:0] w_prod;
    logic [C_DEG_W-1:0]        r_a_deg;
    logic [C_Q_W-1:0]          r_a_q;
    logic [C_FRAC_W-1:0]       r_a_frac;
    logic                      r_a_neg;

    always_comb begin
        w_mag  = r_angle[C_ANGLE_W-1] ? (C_ANGLE_W'(0) - r_angle) : r_angle;
        w_prod = C_RECIP_PROD_W'(w_mag[C_ANGLE_W-1:C_FRAC_W])
               * C_RECIP_PROD_W'(C_RECIP_360);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.stg_a) begin
            r_a_deg  <= w_mag[C_ANGLE_W-1:C_FRAC_W];
            r_a_q    <= w_prod[C_RECIP_SHIFT +: C_Q_W];
            r_a_frac <= w_mag[C_FRAC_W-1:0];
            r_a_neg  <= r_angle[C_ANGLE_W-1];
        end
    end

    // Stage B: remainder, half-turn fold, second-quarter mirror
    logic [C_DEG_W-1:0]  w_rem_full;
    logic [C_REM_W-1:0]  w_rem;
    logic                w_upper;
    logic [C_HALF_W-1:0] w_half;
    logic                w_frac_nz;
    t_fold               n_fold;
    t_fold               r_fold;

    always_comb begin
        w_rem_full = r_a_deg - (C_DEG_W'(r_a_q) * C_DEG_W'(C_FULL_TURN));
        w_rem      = w_rem_full[C_REM_W-1:0];
        w_upper    = (w_rem >= C_HALF_TURN);
        w_half     = w_upper ? C_HALF_W'(w_rem - C_HALF_TURN) : w_rem[C_HALF_W-1:0];
        w_frac_nz  = |r_a_frac;

        n_fold.neg  = r_a_neg ^ w_upper;
        n_fold.idx  = w_half[C_IDX_W-1:0];
        n_fold.frac = r_a_frac;
        if (w_half >= C_QUARTER) begin
            if (w_frac_nz) begin
                n_fold.idx  = C_IDX_W'(C_MIRROR_LO - w_half);
                n_fold.frac = C_FRAC_W'(0) - r_a_frac;
            end else begin
                n_fold.idx  = C_IDX_W'(C_MIRROR_HI - w_half);
            end
        end
        n_fold.interp = w_frac_nz && (n_fold.idx != C_LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.stg_b) begin
            r_fold <= n_fold;
        end
    end

    assign o_fold = r_fold;

endmodule

@@ rtl/sli_interp.sv @@
`timescale 1ns / 1ps

module sli_interp import sli_pkg::*; (
    input  logic                       i_clk,
    input  t_pipe_en                   i_en,
    input  t_fold                      i_fold,
    output logic signed [C_SINE_W-1:0] o_sine
);

    // Stage C: table reads and step to the next entry
    logic [C_VAL_W-1:0]  w_base;
    logic [C_VAL_W-1:0]  w_next;
    logic [C_VAL_W-1:0]  w_step;
    logic [C_VAL_W-1:0]  r_c_base;
    logic [C_DIFF_W-1:0] r_c_diff;
    logic [C_FRAC_W-1:0] r_c_frac;
    logic                r_c_neg;

    always_comb begin
        w_base = sli_quarter(i_fold.idx);
        w_next = sli_quarter(i_fold.idx + C_IDX_W'(1));
        w_step = w_next - w_base;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.stg_c) begin
            r_c_base <= w_base;
            r_c_diff <= i_fold.interp ? w_step[C_DIFF_W-1:0] : '0;
            r_c_frac <= i_fold.frac;
            r_c_neg  <= i_fold.neg;
        end
    end

    // Stage D: interpolate, apply sign
    localparam int C_IPROD_W = C_DIFF_W + C_FRAC_W;

    logic [C_IPROD_W-1:0] w_iprod;
    logic [C_VAL_W-1:0]   w_val;
    logic [C_SINE_W-1:0]  w_mag;
    logic [C_SINE_W-1:0]  r_sine;

    always_comb begin
        w_iprod = C_IPROD_W'(r_c_diff) * C_IPROD_W'(r_c_frac);
        w_val   = r_c_base + C_VAL_W'(w_iprod[C_IPROD_W-1:C_FRAC_W]);
        w_mag   = {1'b0, w_val};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out_reg) begin
            r_sine <= r_c_neg ? (C_SINE_W'(0) - w_mag) : w_mag;
        end
    end

    assign o_sine = r_sine;

endmodule

@@ tb/sine_check_pkg.sv @@
`timescale 1ns / 1ps

package sine_check_pkg;

    // sin(k deg) * 65535, k = 0..90
    localparam logic [15:0] QUARTER_SINE [0:90] = '{
        16'd0,     16'd1144,  16'd2287,  16'd3430,  16'd4571,  16'd5712,  16'd6850,
        16'd7987,  16'd9121,  16'd10252, 16'd11380, 16'd12505, 16'd13625, 16'd14742,
        16'd15854, 16'd16962, 16'd18064, 16'd19161, 16'd20251, 16'd21336, 16'd22414,
        16'd23486, 16'd24550, 16'd25607, 16'd26655, 16'd27696, 16'd28729, 16'd29752,
        16'd30767, 16'd31772, 16'd32768, 16'd33753, 16'd34728, 16'd35693, 16'd36647,
        16'd37589, 16'd38521, 16'd39440, 16'd40347, 16'd41243, 16'd42125, 16'd42995,
        16'd43851, 16'd44695, 16'd45524, 16'd46340, 16'd47142, 16'd47929, 16'd48702,
        16'd49460, 16'd50203, 16'd50930, 16'd51642, 16'd52339, 16'd53019, 16'd53683,
        16'd54331, 16'd54962, 16'd55577, 16'd56174, 16'd56755, 16'd57318, 16'd57864,
        16'd58392, 16'd58902, 16'd59395, 16'd59869, 16'd60325, 16'd60763, 16'd61182,
        16'd61583, 16'd61965, 16'd62327, 16'd62671, 16'd62996, 16'd63302, 16'd63588,
        16'd63855, 16'd64103, 16'd64331, 16'd64539, 16'd64728, 16'd64897, 16'd65047,
        16'd65176, 16'd65286, 16'd65375, 16'd65445, 16'd65495, 16'd65525, 16'd65535
    };

    // Holds the sine values owed for accepted angle requests, oldest first
    class sine_scoreboard;
        logic signed [16:0] owed_sine [$];
        int n_angles;
        int n_checked;
        int n_fail;

        function new();
            n_angles  = 0;
            n_checked = 0;
            n_fail    = 0;
        endfunction

        // Fold to the first quarter, look up, interpolate, restore the sign
        function logic signed [16:0] sine_of(logic signed [24:0] angle);
            logic        neg;
            logic [24:0] mag;
            int unsigned deg;
            int unsigned frac;
            int unsigned base;
            logic [16:0] res;
            neg  = angle[24];
            // most negative angle wraps to magnitude 2^24, which is intended
            mag  = neg ? (25'd0 - angle) : angle;
            deg  = 32'(mag[24:8]);
            frac = 32'(mag[7:0]);
            deg  = deg % 360;
            if (deg >= 180) begin
                deg = deg - 180;
                neg = !neg;
            end
            // second quarter mirrors; a fraction moves the position one entry down
            if (deg >= 90) begin
                deg = 180 - deg;
                if (frac != 0) begin
                    frac = 256 - frac;
                    deg  = deg - 1;
                end
            end
            base = 32'(QUARTER_SINE[deg]);
            if (frac != 0 && deg < 90) begin
                base = base + (((32'(QUARTER_SINE[deg + 1]) - base) * frac) >> 8);
            end
            res = neg ? 17'(0 - base) : 17'(base);
            return res;
        endfunction

        function void note_angle(logic signed [24:0] angle);
            owed_sine = {owed_sine, sine_of(angle)};
            n_angles++;
        endfunction

        function void check_sine(logic signed [16:0] got);
            logic signed [16:0] want;
            if (owed_sine.size() == 0) begin
                $error("sine: no result expected, actual %0d", got);
                n_fail++;
            end else begin
                want = owed_sine.pop_front();
                n_checked++;
                if (got !== want) begin
                    $error("sine: expected %0d, actual %0d", want, got);
                    n_fail++;
                end
            end
        endfunction

        function int pending();
            return owed_sine.size();
        endfunction
    endclass

endpackage

@@ tb/sine_lut_interpolator_top_test.sv @@
`timescale 1ns / 1ps

module sine_lut_interpolator_top_test;
    import sli_pkg::*;
    import sine_check_pkg::*;

    localparam int N_PHASES   = 4;
    localparam int PHASE_REQS = 440;
    localparam int N_DIRECTED = 22;

    // Quarter points, sign extremes, mirrored fractions, negative zero
    localparam int DIRECTED_ANGLES [0:N_DIRECTED-1] = '{
        0, 1, -1, 16777215, -16777215, -16777216,
        23040, -23040, 23041, 23039, 46080, -46080,
        69120, 92160, -92160, 23424, 46079, 22785,
        11648, 92159, 184384, 11184810
    };

    // Idle and stall percentages per phase
    localparam int SEND_IDLE  [0:N_PHASES-1] = '{0, 83, 0, 17};
    localparam int RECV_STALL [0:N_PHASES-1] = '{0, 0, 83, 17};

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic signed [C_ANGLE_W-1:0] i_angle = '0;
    logic                        i_ready = 1'b0;
    logic                        o_ready;
    logic                        o_valid;
    logic signed [C_SINE_W-1:0]  o_sine;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    sine_scoreboard sb = new();

    sine_lut_interpolator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_angle (i_angle),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_sine  (o_sine)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random back-pressure per phase
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_sine(o_sine);
        end
    end

    // Drive one request; entered and left at a falling edge
    task automatic send_angle(input logic signed [C_ANGLE_W-1:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_angle <= angle;
        do @(posedge i_clk); while (!o_ready);
        sb.note_angle(angle);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Mix of full-range noise, small angles, quarter-point neighbors, whole degrees, near-maximum magnitudes
    function automatic logic signed [C_ANGLE_W-1:0] random_angle();
        int unsigned sel;
        logic [24:0] mag;
        logic        neg;
        sel = $urandom_range(9);
        neg = 1'($urandom_range(1));
        case (sel)
            0, 1, 2, 3: begin
                return 25'($urandom());
            end
            4, 5, 6: begin
                mag = 25'($urandom_range(719) * 256 + $urandom_range(255));
            end
            7: begin
                mag = 25'(($urandom_range(180) * 90) * 256 + $urandom_range(3));
                if ($urandom_range(1)) begin
                    mag = mag - 25'($urandom_range(3));
                end
            end
            8: begin
                mag = 25'($urandom_range(65535) * 256);
            end
            default: begin
                mag = 25'(16777215 - $urandom_range(1023));
            end
        endcase
        return neg ? (25'd0 - mag) : mag;
    endfunction

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            if (p == 0) begin
                for (int k = 0; k < N_DIRECTED; k++) begin
                    send_angle(25'(DIRECTED_ANGLES[k]));
                end
            end
            for (int k = 0; k < PHASE_REQS; k++) begin
                send_angle(random_angle());
            end
            // hold off until the pipeline has emptied
            i_valid <= 1'b0;
            wait_drained();
            @(negedge i_clk);
        end

        recv_stall_pct = 0;
        wait_drained();
        repeat (12) @(negedge i_clk);

        $display("Checked %0d sine results for %0d angle requests", sb.n_checked, sb.n_angles);
        $display("Phases: free flow, sender gaps, receiver stalls, mixed light idling");
        if (sb.n_fail == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_pipe_ctrl.sv
rtl/sli_reduce.sv
rtl/sli_interp.sv
rtl/sine_lut_interpolator_top.sv
tb/sine_check_pkg.sv
tb/sine_lut_interpolator_top_test.sv
